@@ hdl/acsr_pkg.sv @@
`timescale 1ns / 1ps
package acsr_pkg;

  localparam logic [31:0] LRU_MARK = 32'hFFFFFF9B;

  localparam logic [2:0] POL_LRU    = 3'd0;
  localparam logic [2:0] POL_LIP    = 3'd1;
  localparam logic [2:0] POL_BIP    = 3'd2;
  localparam logic [2:0] POL_BPLRU  = 3'd3;
  localparam logic [2:0] POL_TPLRU  = 3'd4;
  localparam logic [2:0] POL_SRRIP  = 3'd5;
  localparam logic [2:0] POL_BRRIP  = 3'd6;
  localparam logic [2:0] POL_RANDOM = 3'd7;

  localparam logic [1:0] ST_NEVER   = 2'd0;
  localparam logic [1:0] ST_EMPTIED = 2'd1;
  localparam logic [1:0] ST_VALID   = 2'd2;

  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_EVICT = 1'b1;

  localparam logic [2:0] CFG_POLICY  = 3'd0;
  localparam logic [2:0] CFG_INVFST  = 3'd1;
  localparam logic [2:0] CFG_RRPVB   = 3'd2;
  localparam logic [2:0] CFG_BIPPCT  = 3'd3;
  localparam logic [2:0] CFG_BRRPCT  = 3'd4;

  typedef struct packed {
    logic        req_type;
    logic [31:0] tag;
    logic [6:0]  rand_pct;
    logic [3:0]  rand_way;
  } item_t;

  typedef struct packed {
    logic [2:0] policy;
    logic       invalid_first;
    logic [3:0] rrpv_bits;
    logic [6:0] bip_mru_percent;
    logic [6:0] brrip_near_percent;
  } cfg_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

endpackage

@@ hdl/assoc_cache_set_replacement_unit.sv @@
`timescale 1ns / 1ps
// Fully associative cache set with selectable replacement (LRU, LIP, BIP, bit-PLRU,
// tree-PLRU, SRRIP, BRRIP, random). Accepted beats enter a two-deep queue; an engine
// behind it handles one access at a time. A beat accepted into an empty queue reaches
// the queue head the cycle after it is accepted. A popped access is looked up in S_LOOK,
// where a hit or an evict writes its result. A miss filled by invalid-first, bit-PLRU,
// tree-PLRU or random goes on to S_FILL; an LRU/LIP/BIP miss first scans one way per
// cycle in S_SCAN, and an SRRIP/BRRIP miss first ages all ways in S_AGE until one holds
// the top RRPV. The result sits in an output register and the engine pops nothing until
// it is taken; meanwhile the queue keeps taking beats until it holds two.
module assoc_cache_set_replacement_unit #(
  parameter int WAYS     = 16,
  parameter int TAG_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [31:0] in_tag,
  input  logic [6:0]  in_rand_pct,
  input  logic [3:0]  in_rand_way,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_hit,
  output logic [3:0]  out_way,
  output logic [1:0]  out_victim_status,
  output logic [31:0] out_victim_tag,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [6:0]  cfg_data
);
  import acsr_pkg::*;

  localparam bit POW2 = ((WAYS & (WAYS - 1)) == 0);

  cfg_t    cfg_r;
  logic    cfg_we, cfg_clr;
  item_t   in_item;
  q_head_t q_head;
  logic    q_pop;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign cfg_clr   = cfg_we && (cfg_index == CFG_POLICY);
  assign in_item   = '{req_type: in_req_type, tag: in_tag,
                       rand_pct: in_rand_pct, rand_way: in_rand_way};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{policy: POL_LRU, invalid_first: 1'b0, rrpv_bits: 4'd5,
                 bip_mru_percent: 7'd1, brrip_near_percent: 7'd1};
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POLICY: cfg_r.policy <= (cfg_data[2:0] == POL_TPLRU && !POW2) ? POL_BPLRU
                                                                         : cfg_data[2:0];
        CFG_INVFST: cfg_r.invalid_first      <= cfg_data[0];
        CFG_RRPVB:  cfg_r.rrpv_bits          <= cfg_data[3:0];
        CFG_BIPPCT: cfg_r.bip_mru_percent    <= cfg_data;
        CFG_BRRPCT: cfg_r.brrip_near_percent <= cfg_data;
        default: ;
      endcase
    end
  end

  acsr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_head   (q_head),
    .q_pop    (q_pop)
  );

  acsr_back #(.WAYS(WAYS), .TAG_BITS(TAG_BITS)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .cfg_clr           (cfg_clr),
    .q_head            (q_head),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_hit           (out_hit),
    .out_way           (out_way),
    .out_victim_status (out_victim_status),
    .out_victim_tag    (out_victim_tag)
  );
endmodule

@@ hdl/acsr_front.sv @@
`timescale 1ns / 1ps
module acsr_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  acsr_pkg::item_t in_item,
  output acsr_pkg::q_head_t q_head,
  input  logic            q_pop
);
  import acsr_pkg::*;

  item_t      mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;

  assign in_ready    = (cnt_r != 2'd2);
  assign push        = in_valid && in_ready;
  assign q_head.valid = (cnt_r != 2'd0);
  assign q_head.item  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        mem_r[wp_r] <= in_item;
        wp_r        <= ~wp_r;
      end
      if (q_pop) rp_r <= ~rp_r;
      case ({push, q_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end
endmodule

@@ hdl/acsr_back.sv @@
`timescale 1ns / 1ps
module acsr_back #(
  parameter int WAYS     = 16,
  parameter int TAG_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  acsr_pkg::cfg_t    cfg,
  input  logic              cfg_clr,
  input  acsr_pkg::q_head_t q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_hit,
  output logic [3:0]        out_way,
  output logic [1:0]        out_victim_status,
  output logic [31:0]       out_victim_tag
);
  import acsr_pkg::*;

  localparam int WW     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int TB     = (TAG_BITS < 32) ? TAG_BITS : 32;
  localparam int LEVELS = $clog2(WAYS + 1) - 1;
  localparam int TREE_N = ((1 << LEVELS) - 1 > 0) ? (1 << LEVELS) - 1 : 1;
  localparam int TIW    = (TREE_N > 1) ? $clog2(TREE_N) : 1;
  localparam int CW     = $clog2(WAYS + 1);
  localparam logic [WW-1:0] LAST = WW'(WAYS - 1);

  typedef enum logic [2:0] {S_IDLE, S_LOOK, S_SCAN, S_AGE, S_FILL} state_t;

  state_t          state_r;
  item_t           item_r;
  logic [TB-1:0]   tag_r    [WAYS];
  logic [1:0]      status_r [WAYS];
  logic [31:0]     stamp_r  [WAYS];
  logic [7:0]      rrpv_r   [WAYS];
  logic [31:0]     tick_r;
  logic [WAYS-1:0] used_r;
  logic [CW-1:0]   used_cnt_r;
  logic [TREE_N-1:0] tree_r;
  logic [WW-1:0]   w_r, scan_i_r, cand_r;
  logic [31:0]     oldest_r;
  logic            out_valid_r, out_hit_r;
  logic [3:0]      out_way_r;
  logic [1:0]      out_vstat_r;
  logic [31:0]     out_vtag_r;

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_way           = out_way_r;
  assign out_victim_status = out_vstat_r;
  assign out_victim_tag    = out_vtag_r;

  assign q_pop = (state_r == S_IDLE) && q_head.valid && !out_valid_r;

  // lookup
  logic          hit_any, emp_any, unused_any, rmax_any;
  logic [WW-1:0] hit_w, emp_w, unused_w, rmax_w, tree_w, rand_w;
  logic [7:0]    rmax;
  logic [3:0]    rb;

  always_comb begin
    rb = cfg.rrpv_bits;
    if (rb == 4'd0) rb = 4'd1;
    if (rb > 4'd8) rb = 4'd8;
    rmax = 8'((9'd1 << rb) - 9'd1);
  end

  always_comb begin
    hit_any = 1'b0; hit_w = '0;
    emp_any = 1'b0; emp_w = '0;
    unused_any = 1'b0; unused_w = '0;
    rmax_any = 1'b0; rmax_w = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (status_r[i] == ST_VALID && tag_r[i] == item_r.tag[TB-1:0]) begin
        hit_any = 1'b1; hit_w = WW'(i);
      end
      if (!used_r[i]) begin
        unused_any = 1'b1; unused_w = WW'(i);
      end
      if (rrpv_r[i] == rmax) begin
        rmax_any = 1'b1; rmax_w = WW'(i);
      end
    end
    for (int i = 0; i < WAYS; i++) begin
      if (status_r[i] == ST_EMPTIED) begin
        emp_any = 1'b1; emp_w = WW'(i);
      end
    end
  end

  // tree walk from the root
  always_comb begin
    logic [WW-1:0]  node;
    logic [TIW-1:0] idx;
    node = '0;
    for (int lv = 0; lv < LEVELS; lv++) begin
      idx  = TIW'((1 << lv) - 1) + TIW'(node);
      node = {node[WW-2:0], tree_r[idx]};
    end
    tree_w = node;
  end

  always_comb begin
    logic [4:0] v;
    v = {1'b0, item_r.rand_way};
    for (int k = 0; k < 8; k++) begin
      if (v >= 5'(WAYS)) v = v - 5'(WAYS);
    end
    rand_w = WW'(v);
  end

  // replacement-state update for one way
  logic          touch_en, touch_fill;
  logic [WW-1:0] touch_w;
  logic          mark;
  logic [TREE_N-1:0] tree_hit, tree_val;

  always_comb begin
    touch_en = 1'b0; touch_fill = 1'b0; touch_w = w_r;
    if (state_r == S_LOOK && hit_any && item_r.req_type == REQ_READ) begin
      touch_en = 1'b1; touch_w = hit_w;
    end
    if (state_r == S_FILL) begin
      touch_en = 1'b1; touch_fill = 1'b1; touch_w = w_r;
    end
    mark = touch_fill && (cfg.policy == POL_LIP ||
           (cfg.policy == POL_BIP && item_r.rand_pct > cfg.bip_mru_percent));
  end

  for (genvar n = 0; n < TREE_N; n++) begin : g_tree
    localparam int LV  = $clog2(n + 2) - 1;
    localparam int POS = n + 1 - (1 << LV);
    always_comb begin
      logic [WW-1:0] pref;
      pref = (touch_w >> (LEVELS - LV)) & WW'((1 << LV) - 1);
      tree_hit[n] = (LEVELS > 0) && (pref == WW'(POS));
      tree_val[n] = (LEVELS > 0) ? ~touch_w[LEVELS-1-LV] : tree_r[n];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      tick_r      <= 32'(WAYS);
      used_r      <= '0;
      used_cnt_r  <= '0;
      tree_r      <= '0;
      for (int i = 0; i < WAYS; i++) begin
        status_r[i] <= ST_NEVER;
        stamp_r[i]  <= 32'(i);
        rrpv_r[i]   <= '0;
      end
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;

      if (cfg_clr) begin
        used_r <= '0;
        tree_r <= '0;
        for (int i = 0; i < WAYS; i++) begin
          stamp_r[i] <= '0;
          rrpv_r[i]  <= '0;
        end
      end

      if (touch_en) begin
        if (mark) begin
          stamp_r[touch_w] <= LRU_MARK;
        end else begin
          stamp_r[touch_w] <= tick_r;
          tick_r           <= tick_r + 32'd1;
        end
        // a full set of used bits restarts with only this way marked
        if (!used_r[touch_w]) begin
          if (used_cnt_r + CW'(1) >= CW'(WAYS)) begin
            used_r     <= WAYS'(1) << touch_w;
            used_cnt_r <= CW'(1);
          end else begin
            used_r     <= used_r | (WAYS'(1) << touch_w);
            used_cnt_r <= used_cnt_r + CW'(1);
          end
        end
        for (int n = 0; n < TREE_N; n++) begin
          if (tree_hit[n]) tree_r[n] <= tree_val[n];
        end
        if (touch_fill) begin
          rrpv_r[touch_w] <= (cfg.policy == POL_BRRIP &&
                              item_r.rand_pct > cfg.brrip_near_percent) ? rmax : rmax - 8'd1;
        end else if (rrpv_r[touch_w] != 8'd0) begin
          rrpv_r[touch_w] <= rrpv_r[touch_w] - 8'd1;
        end
      end

      case (state_r)
        S_IDLE: begin
          if (q_pop) begin
            item_r  <= q_head.item;
            state_r <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (hit_any || item_r.req_type == REQ_EVICT) begin
            if (hit_any && item_r.req_type == REQ_EVICT) status_r[hit_w] <= ST_EMPTIED;
            out_valid_r <= 1'b1;
            out_hit_r   <= hit_any;
            out_way_r   <= hit_any ? 4'(hit_w) : 4'd0;
            out_vstat_r <= ST_NEVER;
            out_vtag_r  <= '0;
            state_r     <= S_IDLE;
          end else if (emp_any && cfg.invalid_first) begin
            w_r <= emp_w; state_r <= S_FILL;
          end else begin
            case (cfg.policy)
              POL_LRU, POL_LIP, POL_BIP: begin
                scan_i_r <= '0;
                oldest_r <= '0;
                cand_r   <= emp_any ? emp_w : '0;
                state_r  <= S_SCAN;
              end
              POL_BPLRU: begin
                w_r <= unused_any ? unused_w : '0; state_r <= S_FILL;
              end
              POL_TPLRU: begin
                w_r <= tree_w; state_r <= S_FILL;
              end
              POL_SRRIP, POL_BRRIP: state_r <= S_AGE;
              default: begin
                w_r <= rand_w; state_r <= S_FILL;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (stamp_r[scan_i_r] == LRU_MARK) begin
            w_r <= scan_i_r; state_r <= S_FILL;
          end else begin
            if (tick_r - stamp_r[scan_i_r] > oldest_r) begin
              oldest_r <= tick_r - stamp_r[scan_i_r];
              cand_r   <= scan_i_r;
            end
            if (scan_i_r == LAST) begin
              w_r <= (tick_r - stamp_r[scan_i_r] > oldest_r) ? scan_i_r : cand_r;
              state_r <= S_FILL;
            end else begin
              scan_i_r <= scan_i_r + WW'(1);
            end
          end
        end
        S_AGE: begin
          if (rmax_any) begin
            w_r <= rmax_w; state_r <= S_FILL;
          end else begin
            for (int i = 0; i < WAYS; i++) begin
              rrpv_r[i] <= ({1'b0, rrpv_r[i]} + 9'd1 > {1'b0, rmax}) ? rmax
                                                                     : rrpv_r[i] + 8'd1;
            end
          end
        end
        S_FILL: begin
          tag_r[w_r]    <= item_r.tag[TB-1:0];
          status_r[w_r] <= ST_VALID;
          out_valid_r   <= 1'b1;
          out_hit_r     <= 1'b0;
          out_way_r     <= 4'(w_r);
          out_vstat_r   <= status_r[w_r];
          out_vtag_r    <= (status_r[w_r] == ST_VALID) ? 32'(tag_r[w_r]) : 32'd0;
          state_r       <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

@@ tb/assoc_cache_set_replacement_checker.sv @@
`timescale 1ns / 1ps
module assoc_cache_set_replacement_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_req_type,
  input  logic [31:0] in_tag,
  input  logic [6:0]  in_rand_pct,
  input  logic [3:0]  in_rand_way,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_hit,
  input  logic [3:0]  out_way,
  input  logic [1:0]  out_victim_status,
  input  logic [31:0] out_victim_tag,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [6:0]  cfg_data,
  output int          fail_count,
  output int          pending,
  output int          lookups_seen
);
  import acsr_pkg::*;

  localparam int NW = 16;

  typedef struct packed {
    logic        hit;
    logic [3:0]  way;
    logic [1:0]  vstat;
    logic [31:0] vtag;
  } access_res_t;

  access_res_t expected_q[$];

  logic [2:0]  m_policy;
  logic        m_invfst;
  logic [3:0]  m_rrpvb;
  logic [6:0]  m_bippct, m_brrpct;
  logic [31:0] m_tag   [NW];
  logic [1:0]  m_st    [NW];
  logic [31:0] m_stamp [NW];
  logic [31:0] m_tick;
  logic        m_used  [NW];
  int          m_used_n;
  logic        m_tree  [NW];
  logic [7:0]  m_rrpv  [NW];

  function automatic logic [7:0] rrpv_top();
    int b;
    b = m_rrpvb;
    if (b < 1) b = 1;
    if (b > 8) b = 8;
    return 8'((1 << b) - 1);
  endfunction

  function automatic void refresh_way(int w, bit fill, logic [6:0] pct);
    int node, bitv;
    logic [7:0] mx;
    mx = rrpv_top();
    if (fill && (m_policy == POL_LIP || (m_policy == POL_BIP && pct > m_bippct)))
      m_stamp[w] = LRU_MARK;
    else begin
      m_stamp[w] = m_tick;
      m_tick += 1;
    end
    if (!m_used[w]) begin
      m_used_n++;
      if (m_used_n >= NW) begin
        foreach (m_used[i]) m_used[i] = 1'b0;
        m_used_n = 1;
      end
      m_used[w] = 1'b1;
    end
    node = 0;
    for (int lv = 0; lv < 4; lv++) begin
      bitv = (w >> (3 - lv)) & 1;
      m_tree[(1 << lv) - 1 + node] = (bitv == 0);
      node = node * 2 + bitv;
    end
    if (fill)
      m_rrpv[w] = (m_policy == POL_BRRIP && pct > m_brrpct) ? mx : mx - 8'd1;
    else if (m_rrpv[w] > 0)
      m_rrpv[w] -= 8'd1;
  endfunction

  function automatic int choose_victim(int cand, logic [3:0] rway);
    logic [31:0] oldest, age;
    int node;
    logic [7:0] mx;
    case (m_policy)
      POL_LRU, POL_LIP, POL_BIP: begin
        oldest = 0;
        for (int i = 0; i < NW; i++) begin
          if (m_stamp[i] == LRU_MARK) return i;
          age = m_tick - m_stamp[i];
          if (age > oldest) begin
            oldest = age;
            cand = i;
          end
        end
        return cand;
      end
      POL_BPLRU: begin
        for (int i = 0; i < NW; i++) if (!m_used[i]) return i;
        return 0;
      end
      POL_TPLRU: begin
        node = 0;
        for (int lv = 0; lv < 4; lv++) node = node * 2 + m_tree[(1 << lv) - 1 + node];
        return node;
      end
      POL_SRRIP, POL_BRRIP: begin
        mx = rrpv_top();
        for (int k = 0; k < 260; k++) begin
          for (int i = 0; i < NW; i++) if (m_rrpv[i] == mx) return i;
          for (int i = 0; i < NW; i++) m_rrpv[i] = (m_rrpv[i] >= mx) ? mx : m_rrpv[i] + 8'd1;
        end
        return 0;
      end
      default: return rway;
    endcase
  endfunction

  function automatic access_res_t predict_access(logic rq, logic [31:0] tg,
                                                 logic [6:0] pct, logic [3:0] rway);
    access_res_t r;
    int emptied, w;
    r = '0;
    emptied = -1;
    for (int i = 0; i < NW; i++) begin
      if (m_st[i] == ST_VALID && m_tag[i] == tg) begin
        if (rq == REQ_EVICT) m_st[i] = ST_EMPTIED;
        else refresh_way(i, 1'b0, pct);
        r.hit = 1'b1;
        r.way = 4'(i);
        return r;
      end
      if (m_st[i] == ST_EMPTIED) emptied = i;
    end
    if (rq == REQ_EVICT) return r;
    if (emptied >= 0 && m_invfst) begin
      w = emptied;
      r.vstat = ST_EMPTIED;
    end else begin
      w = choose_victim(emptied >= 0 ? emptied : 0, rway);
      r.vstat = m_st[w];
      if (m_st[w] == ST_VALID) r.vtag = m_tag[w];
    end
    m_tag[w] = tg;
    m_st[w] = ST_VALID;
    refresh_way(w, 1'b1, pct);
    r.way = 4'(w);
    return r;
  endfunction

  always @(posedge clk) begin
    access_res_t e, got;
    if (!rst_n) begin
      m_policy = POL_LRU; m_invfst = 0; m_rrpvb = 5; m_bippct = 1; m_brrpct = 1;
      for (int i = 0; i < NW; i++) begin
        m_tag[i] = 0; m_st[i] = ST_NEVER; m_stamp[i] = i;
        m_used[i] = 0; m_tree[i] = 0; m_rrpv[i] = 0;
      end
      m_tick = NW;
      m_used_n = 0;
      expected_q.delete();
      fail_count = 0;
      lookups_seen = 0;
    end else begin
      if (out_valid && out_ready) begin
        got = {out_hit, out_way, out_victim_status, out_victim_tag};
        if (expected_q.size() == 0) begin
          $error("unexpected result beat");
          fail_count++;
        end else begin
          e = expected_q.pop_front();
          if (got.hit !== e.hit) begin
            $error("hit exp %0d got %0d", e.hit, got.hit); fail_count++;
          end
          if (got.way !== e.way) begin
            $error("way exp %0d got %0d", e.way, got.way); fail_count++;
          end
          if (got.vstat !== e.vstat) begin
            $error("victim_status exp %0d got %0d", e.vstat, got.vstat); fail_count++;
          end
          if (got.vtag !== e.vtag) begin
            $error("victim_tag exp %h got %h", e.vtag, got.vtag); fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_q.insert(expected_q.size(),
                          predict_access(in_req_type, in_tag, in_rand_pct, in_rand_way));
        lookups_seen++;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_POLICY: begin
            m_policy = cfg_data[2:0];
            for (int i = 0; i < NW; i++) begin
              m_stamp[i] = 0; m_used[i] = 0; m_tree[i] = 0; m_rrpv[i] = 0;
            end
          end
          CFG_INVFST: m_invfst = cfg_data[0];
          CFG_RRPVB:  m_rrpvb = cfg_data[3:0];
          CFG_BIPPCT: m_bippct = cfg_data;
          CFG_BRRPCT: m_brrpct = cfg_data;
          default: ;
        endcase
      end
    end
    pending = expected_q.size();
  end

endmodule

@@ tb/assoc_cache_set_replacement_unit_test.sv @@
`timescale 1ns / 1ps
module assoc_cache_set_replacement_unit_test;
  import acsr_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0, in_req_type = 0;
  logic [31:0] in_tag = 0;
  logic [6:0]  in_rand_pct = 1;
  logic [3:0]  in_rand_way = 0;
  logic        in_ready;
  logic        out_valid, out_hit;
  logic        out_ready = 0;
  logic [3:0]  out_way;
  logic [1:0]  out_victim_status;
  logic [31:0] out_victim_tag;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = 0;
  logic [6:0]  cfg_data = 0;
  int          fail_count, pending, lookups_seen;
  int          idle_pct = 26;
  bit          hold_off = 0;
  int          stuck_cycles = 0;
  logic [31:0] tag_pool [8];

  assoc_cache_set_replacement_unit uut (.*);
  assoc_cache_set_replacement_checker chk (.*);

  always #10 clk = ~clk;

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (!rst_n) out_ready <= 0;
    else if (hold_off) out_ready <= 0;
    else out_ready <= ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles > 20000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // valid stays up between back-to-back beats; the task drops it before a random pause
  task automatic send_access(logic rq, logic [31:0] tg, logic [6:0] pct, logic [3:0] rw);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      do @(negedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1; in_req_type <= rq; in_tag <= tg; in_rand_pct <= pct; in_rand_way <= rw;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [6:0] val);
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk); // worst-case aging scan drains
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic random_burst(int n);
    logic [31:0] tg;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) tg = $urandom();
      else tg = tag_pool[$urandom_range(7)] ^ 32'($urandom_range(15));
      send_access(($urandom_range(4) == 0) ? REQ_EVICT : REQ_READ, tg,
                  ($urandom_range(19) == 0) ? 7'($urandom_range(127)) :
                                              7'($urandom_range(1, 100)),
                  4'($urandom_range(15)));
    end
  endtask

  initial begin
    foreach (tag_pool[i]) tag_pool[i] = $urandom() & 32'hFFFF_FFF0;
    repeat (9) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    // directed: field extremes, fills, hits, evicts, refill of an emptied way
    send_access(REQ_READ, 32'h0, 7'd1, 4'd0);
    send_access(REQ_READ, 32'hFFFF_FFFF, 7'd100, 4'd15);
    send_access(REQ_READ, 32'h0, 7'd127, 4'd0);
    send_access(REQ_EVICT, 32'hFFFF_FFFF, 7'd0, 4'd0);
    send_access(REQ_EVICT, 32'h1234_5678, 7'd50, 4'd7);
    for (int i = 1; i < 18; i++) send_access(REQ_READ, 32'(i * 32'h1111_1111), 7'(i * 7), 4'(i));
    send_access(REQ_READ, 32'hFFFF_FFFF, 7'd1, 4'd0);
    send_access(REQ_EVICT, 32'h1111_1111, 7'd1, 4'd0);
    // walk through every policy and both insertion modes, extremes included
    for (int p = 0; p < 8; p++) begin
      write_reg(CFG_POLICY, 7'(p));
      write_reg(CFG_INVFST, 7'(p & 1));
      write_reg(CFG_RRPVB, (p == 5) ? 7'd8 : (p == 6) ? 7'd0 : 7'($urandom_range(1, 15)));
      write_reg(CFG_BIPPCT, (p < 3) ? 7'd0 : 7'd100);
      write_reg(CFG_BRRPCT, (p == 6) ? 7'd127 : 7'd0);
      if (p == 3) idle_pct = 0;
      random_burst(70);
      idle_pct = 26;
      write_reg(CFG_BIPPCT, 7'($urandom_range(127)));
      write_reg(CFG_BRRPCT, 7'($urandom_range(100)));
      write_reg(CFG_RRPVB, 7'($urandom_range(1, 4)));
      random_burst(70);
    end
    // long receiver hold-off while beats keep coming
    hold_off = 1;
    fork
      begin repeat (200) @(negedge clk); hold_off = 0; end
      random_burst(30);
    join
    for (int k = 0; k < 4; k++) begin
      write_reg(CFG_POLICY, 7'($urandom_range(7)));
      write_reg(CFG_INVFST, 7'($urandom_range(1)));
      random_burst(35);
    end
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    $display("Covered %0d accesses over all eight policies, invalid-first on and off,",
             lookups_seen);
    $display("RRPV widths and insertion thresholds at their extremes.");
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

@@ assoc_cache_set_replacement_unit.f @@
hdl/acsr_pkg.sv
hdl/acsr_front.sv
hdl/acsr_back.sv
hdl/assoc_cache_set_replacement_unit.sv
tb/assoc_cache_set_replacement_checker.sv
tb/assoc_cache_set_replacement_unit_test.sv
